// ===== rtl/rv32m_multiply_divide_top_defines.svh =====
// Assertion macros for the RV32M multiply/divide unit.
// Included by modules that carry concurrent assertions; needs no other file.
`ifndef RV32M_MULTIPLY_DIVIDE_TOP_DEFINES_SVH
`define RV32M_MULTIPLY_DIVIDE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define RVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("RV32M unit assertion failed");
// Next-cycle implication, checked outside reset.
`define RVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("RV32M unit assertion failed");
`else
`define RVM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RVM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rvm_pkg.sv =====
// Package for the RV32M multiply/divide unit: widths, operation codes,
// status codes and the controller state type. Depends on nothing.
`timescale 1ns / 1ps
package rvm_pkg;

    localparam int XLEN  = 32;
    localparam int CNT_W = $clog2(XLEN);

    typedef enum logic [2:0] {
        OP_MUL    = 3'd0,
        OP_MULH   = 3'd1,
        OP_MULHSU = 3'd2,
        OP_MULHU  = 3'd3,
        OP_DIV    = 3'd4,
        OP_DIVU   = 3'd5,
        OP_REM    = 3'd6,
        OP_REMU   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_FIX
    } t_state;

endpackage

// ===== rtl/rv32m_multiply_divide_top.sv =====
// RV32M multiply/divide unit: bit-serial shift-add multiplier and restoring
// divider sharing one set of shift registers. Depends on rvm_pkg and the
// assertion macros in rv32m_multiply_divide_top_defines.svh.
//
//   Channel | Handshake                  | Word
//   --------+----------------------------+------------------------------------------
//   in      | i_in_valid / o_in_ready    | i_cmd, i_first_operand, i_second_operand
//   out     | o_out_valid / i_out_ready  | o_result, o_status
//
// An accepted word goes from the prep state, which turns signed operands into
// magnitudes, to the run state, which steps the shared loop one operand bit
// at a time, then to fix-up, which applies the sign and loads the output register.
// The next word can be taken in fix-up once the output is free, not before.
// Reset is synchronous and active low; it empties the core and the output register.
// A stalled output holds its word; the core finishes the next one and waits in fix-up.
`timescale 1ns / 1ps
`include "rv32m_multiply_divide_top_defines.svh"

module rv32m_multiply_divide_top
    import rvm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [2:0]      i_cmd,
    input  logic [XLEN-1:0] i_first_operand,
    input  logic [XLEN-1:0] i_second_operand,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [XLEN-1:0] o_result,
    output logic [1:0]      o_status
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(XLEN - 1);

    // Control state.
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // Datapath. r_hi is the product high half or the partial remainder;
    // r_lo is the multiplier shifting out or the quotient shifting in.
    t_op              r_op, n_op;
    logic             r_an, n_an;       // take magnitude of first operand
    logic             r_bn, n_bn;       // take magnitude of second operand
    logic             r_neg, n_neg;     // negate the selected result
    t_status          r_status, n_status;
    logic [XLEN:0]    r_hi, n_hi;
    logic [XLEN-1:0]  r_lo, n_lo;
    logic [XLEN-1:0]  r_b, n_b;
    logic [XLEN-1:0]  r_result, n_result;
    t_status          r_ostatus, n_ostatus;

    // Decode of the incoming word.
    t_op              in_op;
    logic             in_a_signed, in_b_signed;
    logic             in_an, in_bn;
    logic             in_is_div, in_bzero, in_ovf;

    // Step and fix-up logic.
    logic [XLEN:0]    mul_sum;
    logic [XLEN:0]    div_shift;
    logic [XLEN+1:0]  div_trial;
    logic             is_mul;
    logic             is_high;
    logic [XLEN-1:0]  sel_val;
    logic             fix_carry;
    logic [XLEN-1:0]  fixed_val;
    logic             out_free;
    logic             fin_go;
    logic             accept;

    assign in_op       = t_op'(i_cmd);
    assign in_is_div   = i_cmd[2];
    assign in_bzero    = (i_second_operand == '0);
    assign in_ovf      = (in_op == OP_DIV || in_op == OP_REM)
                       && (i_first_operand == {1'b1, {(XLEN-1){1'b0}}})
                       && (i_second_operand == '1);

    always_comb begin
        unique case (in_op) inside
            OP_MULH, OP_DIV, OP_REM: begin
                in_a_signed = 1'b1;
                in_b_signed = 1'b1;
            end
            OP_MULHSU: begin
                in_a_signed = 1'b1;
                in_b_signed = 1'b0;
            end
            default: begin
                in_a_signed = 1'b0;
                in_b_signed = 1'b0;
            end
        endcase
    end

    assign in_an = in_a_signed & i_first_operand[XLEN-1];
    assign in_bn = in_b_signed & i_second_operand[XLEN-1];

    // One multiply step: add the multiplicand when the low multiplier bit
    // is set, then shift the whole double word right by one.
    assign mul_sum   = r_lo[0] ? (r_hi + {1'b0, r_b}) : r_hi;

    // One restoring divide step: bring in the next dividend bit and keep
    // the difference only when it does not go negative.
    assign div_shift = {r_hi[XLEN-1:0], r_lo[XLEN-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, r_b};

    assign is_mul  = ~r_op[2];
    assign is_high = is_mul && (r_op != OP_MUL);

    // Result selection and sign fix-up. The negated high half of a 64-bit
    // product gets its carry in only when the low half is all zero.
    always_comb begin
        case (r_op) inside
            OP_MUL, OP_DIV, OP_DIVU: sel_val = r_lo;
            default:                 sel_val = r_hi[XLEN-1:0];
        endcase
    end

    assign fix_carry = is_high ? (r_lo == '0) : 1'b1;
    assign fixed_val = r_neg ? (~sel_val + {{(XLEN-1){1'b0}}, fix_carry}) : sel_val;

    assign out_free   = ~r_out_valid | i_out_ready;
    assign fin_go     = (r_state == S_FIX) && out_free;
    assign o_in_ready = (r_state == S_IDLE) || fin_go;
    assign accept     = i_in_valid & o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_an        = r_an;
        n_bn        = r_bn;
        n_neg       = r_neg;
        n_status    = r_status;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_b         = r_b;
        n_result    = r_result;
        n_ostatus   = r_ostatus;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
            end
            S_PREP: begin
                // Signed operands enter the loop as magnitudes.
                n_lo    = r_an ? (~r_lo + 1'b1) : r_lo;
                n_b     = r_bn ? (~r_b + 1'b1) : r_b;
                n_hi    = '0;
                n_count = '0;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (is_mul) begin
                    n_hi = {1'b0, mul_sum[XLEN:1]};
                    n_lo = {mul_sum[0], r_lo[XLEN-1:1]};
                end else begin
                    if (!div_trial[XLEN+1]) begin
                        n_hi = div_trial[XLEN:0];
                    end else begin
                        n_hi = div_shift;
                    end
                    n_lo = {r_lo[XLEN-2:0], ~div_trial[XLEN+1]};
                end
                n_count = r_count + 1'b1;
                if (r_count == LAST_STEP) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (fin_go) begin
                    n_result    = fixed_val;
                    n_ostatus   = r_status;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Taking a new word overrides the return to idle from fix-up.
        if (accept) begin
            n_op  = in_op;
            n_an  = in_an;
            n_bn  = in_bn;
            n_lo  = i_first_operand;
            n_b   = i_second_operand;
            // Division by zero keeps the all-ones quotient unsigned, and the
            // overflow case comes out right through the normal negation.
            unique case (in_op)
                OP_MULH:        n_neg = in_an ^ in_bn;
                OP_MULHSU:      n_neg = in_an;
                OP_DIV:         n_neg = (in_an ^ in_bn) & ~in_bzero;
                OP_REM:         n_neg = in_an;
                default:        n_neg = 1'b0;
            endcase
            if (in_is_div && in_bzero) begin
                n_status = ST_DIVZ;
            end else if (in_ovf) begin
                n_status = ST_OVF;
            end else begin
                n_status = ST_OK;
            end
            n_state = S_PREP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_an      <= n_an;
        r_bn      <= n_bn;
        r_neg     <= n_neg;
        r_status  <= n_status;
        r_hi      <= n_hi;
        r_lo      <= n_lo;
        r_b       <= n_b;
        r_result  <= n_result;
        r_ostatus <= n_ostatus;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_status    = r_ostatus;

    // A taken word always starts with the magnitude cycle.
    `RVM_ASSERT_NXT(a_accept_prep, i_clk, i_rst_n, accept, r_state == S_PREP)
    // The step loop advances by exactly one bit each cycle until the last.
    `RVM_ASSERT_NXT(a_run_step, i_clk, i_rst_n,
        (r_state == S_RUN) && (r_count != LAST_STEP),
        (r_state == S_RUN) && (r_count == $past(r_count) + 1'b1))
    // The output register is only filled from the fix-up cycle.
    `RVM_ASSERT_NXT(a_out_source, i_clk, i_rst_n,
        (r_state != S_FIX) && !r_out_valid, !r_out_valid)
    // Divide-by-zero status only arises for divide and remainder operations.
    `RVM_ASSERT_IMP(a_divz_op, i_clk, i_rst_n,
        (r_state == S_FIX) && (r_status == ST_DIVZ), r_op[2])
    // Overflow status only arises for signed divide and remainder.
    `RVM_ASSERT_IMP(a_ovf_op, i_clk, i_rst_n,
        (r_state == S_FIX) && (r_status == ST_OVF),
        (r_op == OP_DIV) || (r_op == OP_REM))

endmodule
